### hdl/leo_pkg.sv
// shared types, constants and a helper function of the latency offset estimator
`timescale 1ns / 1ps

package leo_pkg;

	// default fraction bits of the smoothed values
	localparam int FRAC_BITS_DEF = 16;
	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 8;
	// records that can sit in the front pipeline beyond the one being accepted
	localparam int FRONT_INFLIGHT = 2;

	// alpha is unsigned Q0.16
	localparam int ALPHA_FRAC = 16;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [31:0] RTT_LIMIT_RESET = 32'd500000000;
	localparam logic [31:0] OUTLIER_RESET   = 32'd10000000;
	localparam logic [15:0] ALPHA_RESET     = 16'd6554;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_RTT_LIMIT = 2'd0,
		REG_OUTLIER   = 2'd1,
		REG_ALPHA     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] rtt_limit_ns;
		logic [31:0] offset_outlier_ns;
		logic [15:0] alpha_q16;
	} cfg_t;

	// one classified record handed from front to back
	typedef struct packed {
		logic [31:0]        seq;
		logic [31:0]        rtt;
		logic signed [63:0] up;
		logic signed [63:0] down;
		logic signed [63:0] offset;
		logic [63:0]        arrival;
	} qentry_t;

	typedef struct packed {
		logic head_valid;
		logic room;
	} q_status_t;

	typedef enum logic [2:0] {
		BK_CHECK,
		BK_MUL_LO,
		BK_MUL_HI,
		BK_SUM,
		BK_WRITE
	} back_state_t;

	// saturate a 66-bit signed value to signed 64 bits
	function automatic logic signed [63:0] sat64(input logic signed [65:0] v);
		logic signed [63:0] r;
		if (v[65:63] == 3'b000 || v[65:63] == 3'b111) begin
			r = v[63:0];
		end else if (v[65]) begin
			r = {1'b1, {63{1'b0}}};
		end else begin
			r = {1'b0, {63{1'b1}}};
		end
		return r;
	endfunction

endpackage

### hdl/leo_ifs.sv
// channel interfaces of the latency offset estimator
`timescale 1ns / 1ps

interface leo_pong_if;
	logic        valid;
	logic        ready;
	logic [31:0] seq_num;
	logic [63:0] client_time_ns;
	logic [63:0] server_time_ns;
	logic [63:0] arrival_time_ns;

	modport source (
		output valid, seq_num, client_time_ns, server_time_ns, arrival_time_ns,
		input  ready
	);
	modport sink (
		input  valid, seq_num, client_time_ns, server_time_ns, arrival_time_ns,
		output ready
	);
endinterface

interface leo_est_if;
	logic               valid;
	logic               ready;
	logic [31:0]        out_seq;
	logic [31:0]        round_trip_ns;
	logic signed [63:0] uplink_ns;
	logic signed [63:0] downlink_ns;
	logic signed [63:0] offset_ns;
	logic signed [63:0] smooth_offset_q16;
	logic [47:0]        smooth_rtt_q16;
	logic [63:0]        out_arrival_ns;

	modport source (
		output valid, out_seq, round_trip_ns, uplink_ns, downlink_ns, offset_ns,
		       smooth_offset_q16, smooth_rtt_q16, out_arrival_ns,
		input  ready
	);
	modport sink (
		input  valid, out_seq, round_trip_ns, uplink_ns, downlink_ns, offset_ns,
		       smooth_offset_q16, smooth_rtt_q16, out_arrival_ns,
		output ready
	);
endinterface

interface leo_cfg_if;
	import leo_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

### hdl/latency_offset_estimator.sv
// top level of the latency offset estimator
`timescale 1ns / 1ps

// Clock offset estimator for timestamped pong records. Each record carries a
// sequence number and client, server and arrival times in nanoseconds. A record
// whose sequence is not above the last one seen is dropped; every other record
// becomes the last seen sequence. The round trip (arrival - client) must be
// non-negative and within rtt_limit_ns; once the filter has started, the offset
// (uplink minus half the round trip) must also stay within offset_outlier_ns of
// the smoothed offset. A passing record seeds or updates, with weight alpha_q16,
// the smoothed offset and smoothed round trip (FRAC_BITS fraction bits) and
// yields one result. Rate: a front pipeline takes one record every cycle while
// the queue has room, and records dropped as duplicates or for their round trip
// cost nothing further. The estimation engine behind the queue takes one record
// at a time: it drops an outlier in its check state, moves the seeding record
// straight from check to write, and runs each smoothing update through check,
// low multiply, high multiply, sum and write, using two 16x32 multipliers on the
// low and then the high part of the difference. A result passes the front
// stages, the queue and these states into the result register, waiting while
// stalled. Configuration writes are always taken; reset needs no clearing pass.
module latency_offset_estimator #(
	parameter int FRAC_BITS   = leo_pkg::FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = leo_pkg::QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	leo_pong_if.sink  pong,
	leo_est_if.source est,
	leo_cfg_if.sink   cfg
);
	import leo_pkg::*;

	cfg_t      cfg_q;
	q_status_t qstat;
	logic      push;
	qentry_t   push_data;
	logic      pop;
	qentry_t   head;

	// configuration registers, always writable
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rtt_limit_ns      <= RTT_LIMIT_RESET;
			cfg_q.offset_outlier_ns <= OUTLIER_RESET;
			cfg_q.alpha_q16         <= ALPHA_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_RTT_LIMIT: cfg_q.rtt_limit_ns      <= cfg.data[31:0];
				REG_OUTLIER:   cfg_q.offset_outlier_ns <= cfg.data[31:0];
				REG_ALPHA:     cfg_q.alpha_q16         <= cfg.data[15:0];
				// unused index: write is ignored
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	// front: duplicate filter, round-trip check, delays and offset
	leo_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pong      (pong),
		.cfg       (cfg_q),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	// queue decouples the per-cycle front from the multi-cycle filter
	leo_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.status    (qstat)
	);

	// back: outlier check, seeding or ema update, result register
	leo_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.qstat  (qstat),
		.head   (head),
		.pop    (pop),
		.est    (est)
	);

endmodule

### hdl/leo_front.sv
// front end: duplicate filter, round-trip check and delay arithmetic
`timescale 1ns / 1ps

module leo_front (
	input  logic               clk,
	input  logic               arst_n,
	leo_pong_if.sink           pong,
	input  leo_pkg::cfg_t      cfg,
	input  leo_pkg::q_status_t qstat,
	output logic               push,
	output leo_pkg::qentry_t   push_data
);
	import leo_pkg::*;

	logic        acc;
	logic        dup;
	logic [31:0] last_seq_q;
	logic        seq_seen_q;

	logic        v_s1;
	logic [31:0] seq_s1;
	logic [63:0] client_s1;
	logic [63:0] server_s1;
	logic [63:0] arrival_s1;

	logic [64:0]        rtt_diff;
	logic               rtt_ok;
	logic signed [63:0] up;
	logic signed [63:0] down;

	logic               v_s2;
	logic [31:0]        seq_s2;
	logic [31:0]        rtt_s2;
	logic signed [63:0] up_s2;
	logic signed [63:0] down_s2;
	logic [63:0]        arrival_s2;

	// queue room already accounts for records still in this pipeline
	assign pong.ready = qstat.room;
	assign acc        = pong.valid && pong.ready;
	assign dup        = seq_seen_q && (pong.seq_num <= last_seq_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_seq_q <= '0;
			seq_seen_q <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
		end else begin
			if (acc && !dup) begin
				last_seq_q <= pong.seq_num;
				seq_seen_q <= 1'b1;
			end
			v_s1 <= acc && !dup;
			v_s2 <= v_s1 && rtt_ok;
		end
	end

	// stage 1: round trip and one-way delays
	assign rtt_diff = {1'b0, arrival_s1} - {1'b0, client_s1};
	assign rtt_ok   = !rtt_diff[64] && (rtt_diff[63:0] <= {32'b0, cfg.rtt_limit_ns});
	assign up       = sat64($signed({2'b00, server_s1}) - $signed({2'b00, client_s1}));
	assign down     = sat64($signed({2'b00, arrival_s1}) - $signed({2'b00, server_s1}));

	always_ff @(posedge clk) begin
		if (acc && !dup) begin
			seq_s1     <= pong.seq_num;
			client_s1  <= pong.client_time_ns;
			server_s1  <= pong.server_time_ns;
			arrival_s1 <= pong.arrival_time_ns;
		end
		seq_s2     <= seq_s1;
		rtt_s2     <= rtt_diff[31:0];
		up_s2      <= up;
		down_s2    <= down;
		arrival_s2 <= arrival_s1;
	end

	// stage 2: offset is uplink minus half the round trip
	assign push             = v_s2;
	assign push_data.seq    = seq_s2;
	assign push_data.rtt    = rtt_s2;
	assign push_data.up     = up_s2;
	assign push_data.down   = down_s2;
	assign push_data.offset = sat64(66'(up_s2) - $signed({35'b0, rtt_s2[31:1]}));
	assign push_data.arrival = arrival_s2;

endmodule

### hdl/leo_queue.sv
// small register queue between front and back
`timescale 1ns / 1ps

module leo_queue #(
	parameter int DEPTH = leo_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  leo_pkg::qentry_t    push_data,
	input  logic                pop,
	output leo_pkg::qentry_t    head,
	output leo_pkg::q_status_t  status
);
	import leo_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	qentry_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head              = mem_q[rd_ptr_q];
	assign status.head_valid = (count_q != '0);
	// keep space for the records still inside the front pipeline
	assign status.room       = (count_q <= CNT_W'(DEPTH - 1 - FRONT_INFLIGHT));

endmodule

### hdl/leo_back.sv
// back end: outlier check, smoothing filter and result register
`timescale 1ns / 1ps

module leo_back #(
	parameter int FRAC_BITS = leo_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  leo_pkg::cfg_t      cfg,
	input  leo_pkg::q_status_t qstat,
	input  leo_pkg::qentry_t   head,
	output logic               pop,
	leo_est_if.source          est
);
	import leo_pkg::*;

	localparam int RQ_W = 48;

	back_state_t state_q, state_d;

	logic               filter_started_q;
	logic signed [63:0] s_off_q;
	logic [RQ_W-1:0]    s_rtt_q;

	qentry_t            ent_q;
	logic               seed_q;
	logic signed [63:0] x_off_q;
	logic [RQ_W-1:0]    x_rtt_q;
	logic signed [63:0] d_off_q;
	logic signed [48:0] d_rtt_q;
	logic signed [49:0] p_off_lo_q, p_off_hi_q, p_rtt_lo_q, p_rtt_hi_q;
	logic signed [63:0] step_off_q;
	logic signed [48:0] step_rtt_q;

	logic               est_valid_q;
	qentry_t            res_q;
	logic signed [63:0] res_soff_q;
	logic [RQ_W-1:0]    res_srtt_q;

	logic               capture;
	logic               commit;

	logic signed [63:0] x_off;
	logic [RQ_W-1:0]    x_rtt;
	logic signed [63:0] d_off;
	logic signed [48:0] d_rtt;
	logic signed [63:0] s_int;
	logic               frac_nz;
	logic signed [65:0] diff;
	logic signed [65:0] lim;
	logic signed [65:0] low_sum;
	logic               outlier;
	logic [FRAC_BITS:0] off_top;

	logic signed [16:0] alpha_s;
	logic signed [32:0] mop_off;
	logic signed [32:0] mop_rtt;
	logic signed [49:0] prod_off;
	logic signed [49:0] prod_rtt;
	logic signed [81:0] acc_off;
	logic signed [81:0] acc_rtt;

	logic signed [63:0] new_off;
	logic [RQ_W-1:0]    new_rtt;

	// new sample in fixed point, offset saturated
	assign off_top = head.offset[63:63-FRAC_BITS];
	always_comb begin
		if (&off_top || ~|off_top) begin
			x_off = head.offset <<< FRAC_BITS;
		end else if (head.offset[63]) begin
			x_off = {1'b1, {63{1'b0}}};
		end else begin
			x_off = {1'b0, {63{1'b1}}};
		end
	end
	assign x_rtt = RQ_W'({head.rtt, {FRAC_BITS{1'b0}}});

	assign d_off = sat64(66'(x_off) - 66'(s_off_q));
	assign d_rtt = $signed({1'b0, x_rtt}) - $signed({1'b0, s_rtt_q});

	// exact distance of offset from the smoothed offset
	assign s_int   = s_off_q >>> FRAC_BITS;
	assign frac_nz = |s_off_q[FRAC_BITS-1:0];
	assign diff    = 66'(head.offset) - 66'(s_int);
	assign lim     = $signed({34'b0, cfg.offset_outlier_ns});
	assign low_sum = diff + lim;
	assign outlier = filter_started_q &&
	                 ((diff > lim) || (low_sum < 0) || ((low_sum == 0) && frac_nz));

	// ema multiply split into the low 32 bits and the remaining high bits of the difference
	assign alpha_s  = $signed({1'b0, cfg.alpha_q16});
	assign mop_off  = (state_q == BK_MUL_LO) ? $signed({1'b0, d_off_q[31:0]})
	                                         : $signed({d_off_q[63], d_off_q[63:32]});
	assign mop_rtt  = (state_q == BK_MUL_LO) ? $signed({1'b0, d_rtt_q[31:0]})
	                                         : $signed({{16{d_rtt_q[48]}}, d_rtt_q[48:32]});
	assign prod_off = alpha_s * mop_off;
	assign prod_rtt = alpha_s * mop_rtt;

	assign acc_off = $signed({p_off_hi_q, 32'b0}) + 82'(p_off_lo_q);
	assign acc_rtt = $signed({p_rtt_hi_q, 32'b0}) + 82'(p_rtt_lo_q);

	assign new_off = seed_q ? x_off_q : s_off_q + step_off_q;
	assign new_rtt = seed_q ? x_rtt_q : s_rtt_q + step_rtt_q[RQ_W-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_CHECK: begin
				if (capture) begin
					state_d = filter_started_q ? BK_MUL_LO : BK_WRITE;
				end
			end
			BK_MUL_LO: state_d = BK_MUL_HI;
			BK_MUL_HI: state_d = BK_SUM;
			BK_SUM:    state_d = BK_WRITE;
			BK_WRITE: begin
				if (commit) begin
					state_d = BK_CHECK;
				end
			end
			default:   state_d = BK_CHECK;
		endcase
	end

	always_comb begin
		pop     = 1'b0;
		capture = 1'b0;
		commit  = 1'b0;
		case (state_q)
			BK_CHECK: begin
				pop     = qstat.head_valid;
				capture = qstat.head_valid && !outlier;
			end
			BK_WRITE: commit = !est_valid_q || est.ready;
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= BK_CHECK;
			filter_started_q <= 1'b0;
			s_off_q          <= '0;
			s_rtt_q          <= '0;
			est_valid_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				filter_started_q <= 1'b1;
				s_off_q          <= new_off;
				s_rtt_q          <= new_rtt;
				est_valid_q      <= 1'b1;
			end else if (est.ready) begin
				est_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			ent_q   <= head;
			seed_q  <= !filter_started_q;
			x_off_q <= x_off;
			x_rtt_q <= x_rtt;
			d_off_q <= d_off;
			d_rtt_q <= d_rtt;
		end
		if (state_q == BK_MUL_LO) begin
			p_off_lo_q <= prod_off;
			p_rtt_lo_q <= prod_rtt;
		end
		if (state_q == BK_MUL_HI) begin
			p_off_hi_q <= prod_off;
			p_rtt_hi_q <= prod_rtt;
		end
		if (state_q == BK_SUM) begin
			step_off_q <= acc_off[63+ALPHA_FRAC:ALPHA_FRAC];
			step_rtt_q <= acc_rtt[48+ALPHA_FRAC:ALPHA_FRAC];
		end
		if (commit) begin
			res_q      <= ent_q;
			res_soff_q <= new_off;
			res_srtt_q <= new_rtt;
		end
	end

	assign est.valid             = est_valid_q;
	assign est.out_seq           = res_q.seq;
	assign est.round_trip_ns     = res_q.rtt;
	assign est.uplink_ns         = res_q.up;
	assign est.downlink_ns       = res_q.down;
	assign est.offset_ns         = res_q.offset;
	assign est.smooth_offset_q16 = res_soff_q;
	assign est.smooth_rtt_q16    = res_srtt_q;
	assign est.out_arrival_ns    = res_q.arrival;

endmodule

### hdl/leo_checker.sv
// port-level assertions of the latency offset estimator, bound to the top level
`timescale 1ns / 1ps

module leo_checker #(
	parameter int FRAC_BITS = leo_pkg::FRAC_BITS_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             est_valid,
	input logic                             est_ready,
	input logic [31:0]                      est_out_seq,
	input logic [31:0]                      est_round_trip,
	input logic signed [63:0]               est_offset,
	input logic signed [63:0]               est_smooth_offset,
	input logic [47:0]                      est_smooth_rtt,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic [leo_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input logic [leo_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import leo_pkg::*;

	logic [31:0] lim_q;
	logic [31:0] last_q;
	logic        seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q  <= RTT_LIMIT_RESET;
			last_q <= '0;
			seen_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready && (cfg_index == REG_RTT_LIMIT)) begin
				lim_q <= cfg_data[31:0];
			end
			if (est_valid && est_ready) begin
				last_q <= est_out_seq;
				seen_q <= 1'b1;
			end
		end
	end

	// a stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		est_valid && !est_ready |=> est_valid && $stable(est_out_seq) &&
		$stable(est_offset) && $stable(est_smooth_offset))
		else $error("result changed while stalled");

	// no result carries a round trip above the configured limit
	a_rtt: assert property (@(posedge clk) disable iff (!arst_n)
		est_valid |-> est_round_trip <= lim_q)
		else $error("result round trip above limit");

	// results come out in strictly rising sequence order
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		est_valid && seen_q |-> est_out_seq > last_q)
		else $error("result sequence not rising");

	// the first result seeds the smoothed round trip with its own sample
	a_seed: assert property (@(posedge clk) disable iff (!arst_n)
		est_valid && !seen_q |->
		est_smooth_rtt == 48'({est_round_trip, {FRAC_BITS{1'b0}}}))
		else $error("first result not seeded from its round trip");

endmodule

bind latency_offset_estimator leo_checker #(
	.FRAC_BITS (FRAC_BITS)
) u_leo_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.est_valid         (est.valid),
	.est_ready         (est.ready),
	.est_out_seq       (est.out_seq),
	.est_round_trip    (est.round_trip_ns),
	.est_offset        (est.offset_ns),
	.est_smooth_offset (est.smooth_offset_q16),
	.est_smooth_rtt    (est.smooth_rtt_q16),
	.cfg_valid         (cfg.valid),
	.cfg_ready         (cfg.ready),
	.cfg_index         (cfg.index),
	.cfg_data          (cfg.data)
);
